// ----- sv/cft_pkg.sv -----
`timescale 1ns / 1ps

package cft_pkg;

    localparam logic [7:0] QUOTE_BYTE  = 8'd34;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] SPACE_BYTE  = 8'd32;
    localparam logic [7:0] TAB_BYTE    = 8'd9;
    localparam logic [7:0] CR_BYTE     = 8'd13;

    // wide enough for a pending count up to the largest store depth (63)
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 4;

    // one command per input byte that causes results
    typedef struct packed {
        logic [CNT_W-1:0] flush_cnt;
        logic [7:0]       data;
        logic             byte_valid;
        logic             field_done;
        logic             line_done;
        logic             spaces_lost;
        logic             extra_line;
    } cmd_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == SPACE_BYTE) || ((c >= TAB_BYTE) && (c <= CR_BYTE));
    endfunction

endpackage

// ----- sv/cft_in_if.sv -----
`timescale 1ns / 1ps

interface cft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_end;

    modport source (output valid, output in_byte, output line_end, input ready);
    modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

// ----- sv/cft_out_if.sv -----
`timescale 1ns / 1ps

interface cft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_done;
    logic       line_done;
    logic       last_of_run;
    logic       spaces_lost;

    modport source (
        output valid, output out_byte, output byte_valid, output field_done,
        output line_done, output last_of_run, output spaces_lost, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input field_done,
        input line_done, input last_of_run, input spaces_lost, output ready
    );
endinterface

// ----- sv/cft_ram.sv -----
`timescale 1ns / 1ps

module cft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/cft_fifo.sv -----
`timescale 1ns / 1ps

module cft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [PW:0]      wr_ptr_reg;
    logic [PW:0]      wr_ptr_next;
    logic [PW:0]      rd_ptr_reg;
    logic [PW:0]      rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]) &&
                   (wr_ptr_reg[PW] != rd_ptr_reg[PW]);
    assign rdata = storage_reg[rd_ptr_reg[PW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + (PW+1)'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[wr_ptr_reg[PW-1:0]] <= wdata;
        end
    end

endmodule

// ----- sv/cft_front.sv -----
`timescale 1ns / 1ps

module cft_front import cft_pkg::*; #(
    parameter int PENDING_DEPTH = 16,
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
    localparam int CW = $clog2(PENDING_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    cft_in_if.sink        in_ch,
    input  logic          fifo_full,
    output logic          fifo_push,
    output cmd_t          fifo_wdata,
    output logic          st_wr_en,
    output logic [AW-1:0] st_wr_addr,
    output logic [7:0]    st_wr_data,
    input  logic          flush_done
);

    logic [7:0]    delim_reg;
    logic          in_quotes_reg;
    logic          in_quotes_next;
    logic          quote_seen_reg;
    logic          quote_seen_next;
    logic          started_reg;
    logic          started_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          flush_busy_reg;
    logic          flush_busy_next;

    logic [7:0] c;
    logic       le;
    logic       is_q;
    logic       is_d;
    logic       ws;
    logic       do_content;
    logic       do_delim;
    logic       byte_out;
    logic       wr_need;
    logic       ovf_set;
    logic       ovf_now;
    logic       need_push;
    logic       accept;

    assign c    = in_ch.in_byte;
    assign le   = in_ch.line_end;
    assign is_q = (c == QUOTE_BYTE);
    assign is_d = (c == delim_reg);
    assign ws   = is_ws(c);

    // quote handling with one byte of lookahead after a quote inside a span
    always_comb
    begin
        do_content      = 1'b0;
        do_delim        = 1'b0;
        in_quotes_next  = in_quotes_reg;
        quote_seen_next = quote_seen_reg;
        if (in_quotes_reg)
        begin
            if (quote_seen_reg)
            begin
                quote_seen_next = 1'b0;
                if (is_q)
                begin
                    do_content = 1'b1;
                end
                else
                begin
                    in_quotes_next = 1'b0;
                    if (is_d)
                    begin
                        do_delim = 1'b1;
                    end
                    else
                    begin
                        do_content = 1'b1;
                    end
                end
            end
            else if (is_q)
            begin
                quote_seen_next = 1'b1;
            end
            else
            begin
                do_content = 1'b1;
            end
        end
        else if (is_q)
        begin
            in_quotes_next = 1'b1;
        end
        else if (is_d)
        begin
            do_delim = 1'b1;
        end
        else
        begin
            do_content = 1'b1;
        end
    end

    assign byte_out  = do_content && !ws;
    assign wr_need   = do_content && ws && started_reg && (count_reg < CW'(PENDING_DEPTH));
    assign ovf_set   = do_content && ws && started_reg && (count_reg == CW'(PENDING_DEPTH));
    assign ovf_now   = ovf_reg || ovf_set;
    assign need_push = byte_out || do_delim || le;

    // the store may not be refilled while the back still reads an earlier run
    assign in_ch.ready = !fifo_full && !(wr_need && flush_busy_reg);
    assign accept      = in_ch.valid && in_ch.ready;
    assign fifo_push   = accept && need_push;

    always_comb
    begin
        fifo_wdata.flush_cnt   = byte_out ? CNT_W'(count_reg) : '0;
        fifo_wdata.data        = c;
        fifo_wdata.byte_valid  = byte_out;
        fifo_wdata.field_done  = do_delim || le;
        fifo_wdata.line_done   = le && !do_delim;
        fifo_wdata.spaces_lost = (do_delim || le) && ovf_now;
        fifo_wdata.extra_line  = le && do_delim;
    end

    assign st_wr_en   = accept && wr_need;
    assign st_wr_addr = count_reg[AW-1:0];
    assign st_wr_data = c;

    always_comb
    begin
        started_next    = started_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        flush_busy_next = flush_busy_reg;
        if (flush_done)
        begin
            flush_busy_next = 1'b0;
        end
        if (fifo_push && byte_out && (count_reg != '0))
        begin
            flush_busy_next = 1'b1;
        end
        if (byte_out)
        begin
            count_next   = '0;
            started_next = 1'b1;
        end
        if (wr_need)
        begin
            count_next = count_reg + CW'(1);
        end
        if (ovf_set)
        begin
            ovf_next = 1'b1;
        end
        if (do_delim || le)
        begin
            started_next = 1'b0;
            count_next   = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg      <= DELIM_RESET;
            in_quotes_reg  <= 1'b0;
            quote_seen_reg <= 1'b0;
            started_reg    <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            flush_busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delim_reg <= cfg_wdata;
            end
            flush_busy_reg <= flush_busy_next;
            if (accept)
            begin
                in_quotes_reg  <= le ? 1'b0 : in_quotes_next;
                quote_seen_reg <= le ? 1'b0 : quote_seen_next;
                started_reg    <= started_next;
                count_reg      <= count_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

endmodule

// ----- sv/cft_back.sv -----
`timescale 1ns / 1ps

module cft_back import cft_pkg::*; #(
    parameter int PENDING_DEPTH = 16,
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fifo_empty,
    input  cmd_t          fifo_rdata,
    output logic          fifo_pop,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    output logic          flush_done,
    cft_out_if.source     out_ch
);

    typedef enum logic [4:0] {
        BK_IDLE  = 5'b00001,
        BK_READ  = 5'b00010,
        BK_EMIT  = 5'b00100,
        BK_MAIN  = 5'b01000,
        BK_EXTRA = 5'b10000
    } back_state_t;

    back_state_t      state_reg;
    back_state_t      state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] idx_inc;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       field_done_reg;
    logic       line_done_reg;
    logic       last_reg;
    logic       spaces_lost_reg;

    logic       slot_free;
    logic       load;
    logic [7:0] n_byte;
    logic       n_bv;
    logic       n_fd;
    logic       n_ld;
    logic       n_last;
    logic       n_sl;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign rd_addr   = idx_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        fifo_pop   = 1'b0;
        flush_done = 1'b0;
        load       = 1'b0;
        n_byte     = 8'd0;
        n_bv       = 1'b0;
        n_fd       = 1'b0;
        n_ld       = 1'b0;
        n_last     = 1'b0;
        n_sl       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    cmd_next   = fifo_rdata;
                    idx_next   = '0;
                    state_next = (fifo_rdata.flush_cnt != '0) ? BK_READ : BK_MAIN;
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                // read data stays put since the address holds until the transfer
                if (slot_free)
                begin
                    load     = 1'b1;
                    n_byte   = rd_data;
                    n_bv     = 1'b1;
                    idx_next = idx_inc;
                    if (idx_inc == cmd_reg.flush_cnt)
                    begin
                        flush_done = 1'b1;
                        state_next = BK_MAIN;
                    end
                    else
                    begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_MAIN:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    n_byte     = cmd_reg.byte_valid ? cmd_reg.data : 8'd0;
                    n_bv       = cmd_reg.byte_valid;
                    n_fd       = cmd_reg.field_done;
                    n_ld       = cmd_reg.line_done;
                    n_sl       = cmd_reg.spaces_lost;
                    n_last     = !cmd_reg.extra_line;
                    state_next = cmd_reg.extra_line ? BK_EXTRA : BK_IDLE;
                end
            end
            BK_EXTRA:
            begin
                // empty last field after a delimiter that closes the line
                if (slot_free)
                begin
                    load       = 1'b1;
                    n_fd       = 1'b1;
                    n_ld       = 1'b1;
                    n_last     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            out_byte_reg    <= n_byte;
            byte_valid_reg  <= n_bv;
            field_done_reg  <= n_fd;
            line_done_reg   <= n_ld;
            last_reg        <= n_last;
            spaces_lost_reg <= n_sl;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.byte_valid  = byte_valid_reg;
    assign out_ch.field_done  = field_done_reg;
    assign out_ch.line_done   = line_done_reg;
    assign out_ch.last_of_run = last_reg;
    assign out_ch.spaces_lost = spaces_lost_reg;

endmodule

// ----- sv/csv_field_tokenizer_top.sv -----
`timescale 1ns / 1ps

// csv field tokenizer: one byte of a csv line per input transfer on in_ch,
// with line_end set on the line's last byte. out_ch gives the trimmed
// field bytes, each result carrying field_done, line_done, last_of_run and
// spaces_lost. A byte may cause no result or up to PENDING_DEPTH+1 results.
// cfg_we/cfg_wdata set the delimiter byte (comma after reset); write it
// only while the block is idle.
// The front classifies each byte in the cycle it is taken and queues at most one
// command; the back sequencer turns commands into results through a
// single output register.
// A result passes through the command queue, the back's command register
// and the output register. The back returns to idle after each command,
// and each flushed whitespace byte passes a read and an emit state
// (registered read of the pending store). Input is taken every cycle while
// the 4-entry command queue has room; a byte that adds to the pending store
// waits until the back has read out the previous run of whitespace.
// Reset clears quote state, field state, the queue and the output; the
// pending store itself is not cleared. When out_ch stalls, the output
// register holds, the queue fills and then in_ch.ready drops.
module csv_field_tokenizer_top import cft_pkg::*; #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    cft_in_if.sink     in_ch,
    cft_out_if.source  out_ch
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    logic          fifo_push;
    logic          fifo_pop;
    logic          fifo_full;
    logic          fifo_empty;
    cmd_t          fifo_wdata;
    cmd_t          fifo_rdata;
    logic          st_wr_en;
    logic [AW-1:0] st_wr_addr;
    logic [7:0]    st_wr_data;
    logic [AW-1:0] st_rd_addr;
    logic [7:0]    st_rd_data;
    logic          flush_done;

    cft_front #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .fifo_full  (fifo_full),
        .fifo_push  (fifo_push),
        .fifo_wdata (fifo_wdata),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .flush_done (flush_done)
    );

    cft_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (fifo_wdata),
        .pop   (fifo_pop),
        .rdata (fifo_rdata),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    cft_ram #(
        .WIDTH(8),
        .DEPTH(PENDING_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    cft_back #(
        .PENDING_DEPTH(PENDING_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_rdata (fifo_rdata),
        .fifo_pop   (fifo_pop),
        .rd_addr    (st_rd_addr),
        .rd_data    (st_rd_data),
        .flush_done (flush_done),
        .out_ch     (out_ch)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("command popped from an empty queue");

    a_no_write_at_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        flush_done |-> !st_wr_en)
        else $error("pending store written while its run is still read");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.byte_valid) |-> (out_ch.out_byte == 8'd0))
        else $error("result without a byte carries a nonzero byte");

    a_lost_at_field_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.spaces_lost) |-> out_ch.field_done)
        else $error("spaces_lost set outside a field end");

endmodule
